FILE: sv/bahd_pkg.sv
// Shared types, constants and lookup functions for the Basic auth header decoder.
package bahd_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharNul   = 8'h00;
   localparam logic [2:0] SchemeLen = 3'd6;

   // parse phase of the front end, one-hot
   typedef enum logic [5:0] {
      PH_LEAD   = 6'b000001,
      PH_MATCH  = 6'b000010,
      PH_SKIP   = 6'b000100,
      PH_DECODE = 6'b001000,
      PH_DONE   = 6'b010000,
      PH_FAIL   = 6'b100000
   } phase_type;

   // decoded work for one header byte, handed from front to back
   typedef struct packed {
      logic [2:0][7:0] bytes;      // bytes[0] goes out first
      logic [1:0]      nbytes;
      logic            has_status;
      logic            front_ok;   // scheme matched and payload seen
   } entry_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      nbytes;
   } flush_type;

   // characters of the scheme word, lower case
   function automatic logic [7:0] scheme_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h62; // b
         3'd1:    ch = 8'h61; // a
         3'd2:    ch = 8'h73; // s
         3'd3:    ch = 8'h69; // i
         3'd4:    ch = 8'h63; // c
         3'd5:    ch = CharSpace;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // base64 alphabet; bit 6 set means not in the alphabet
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] s;
      if (c inside {[8'h41:8'h5A]}) begin
         s = {1'b0, 6'(c - 8'h41)};
      end else if (c inside {[8'h61:8'h7A]}) begin
         s = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c inside {[8'h30:8'h39]}) begin
         s = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         s = 7'd62;
      end else if (c == 8'h2F) begin
         s = 7'd63;
      end else begin
         s = 7'd64;
      end
      return s;
   endfunction

   // bytes of an open partial group; a lone sextet gives nothing
   function automatic flush_type group_flush(input logic [17:0] grp, input logic [1:0] cnt);
      flush_type f;
      f.bytes  = '0;
      f.nbytes = 2'd0;
      case (cnt)
         2'd2: begin
            f.bytes[0] = grp[11:4];
            f.nbytes   = 2'd1;
         end
         2'd3: begin
            f.bytes[0] = grp[17:10];
            f.bytes[1] = grp[9:2];
            f.nbytes   = 2'd2;
         end
         default: begin
            f.nbytes = 2'd0;
         end
      endcase
      return f;
   endfunction

endpackage

FILE: sv/bahd_req_if.sv
// Input channel: one header byte per transfer.
interface bahd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic       is_last;

   modport source (output valid, output header_byte, output is_last, input ready);
   modport sink   (input valid, input header_byte, input is_last, output ready);
endinterface

FILE: sv/bahd_rsp_if.sv
// Result channel: one credential byte or the final status per transfer.
interface bahd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_password;
   logic       is_status;
   logic       status;
   logic       last;

   modport source (output valid, output data_byte, output is_password, output is_status,
                   output status, output last, input ready);
   modport sink   (input valid, input data_byte, input is_password, input is_status,
                   input status, input last, output ready);
endinterface

FILE: sv/basic_auth_header_decoder.sv
// Top level of the HTTP Basic authorization header decoder.
// Takes the Authorization header value one byte per transfer on req_chan and returns
// decoded user name bytes (is_password 0), password bytes (is_password 1) and, after
// the byte marked is_last, one status result (is_status 1, last 1, status 0 ok, 1 fail).
// On fail the bytes given for that header are to be discarded. The front end takes one
// header byte per cycle while the queue is not full, with no gaps of its own; the back
// end gives one result per cycle while rsp_chan is ready, so a byte that closes a base64
// group with three output bytes plus the status gives four results. A four-entry queue
// between the two absorbs such bursts; the sustained rate is set by the back end's one
// result per cycle, which averages well under one per input byte for base64 text (three
// bytes per four characters). Results pass through the queue and the output register.
module basic_auth_header_decoder (
   input  logic        clock,
   input  logic        reset,
   bahd_req_if.sink    req_chan,
   bahd_rsp_if.source  rsp_chan
);
   import bahd_pkg::*;

   logic      push, pop, queue_full, head_valid;
   entry_type push_entry, head_entry;

   bahd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   bahd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   bahd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: sv/bahd_front.sv
// Front end: scheme match, space skipping and base64 sextet grouping.
module bahd_front (
   input  logic                clock,
   input  logic                reset,
   bahd_req_if.sink            req_chan,
   input  logic                queue_full,
   output logic                push,
   output bahd_pkg::entry_type push_entry
);
   import bahd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  match_ff, match_in;
   logic [17:0] grp_ff, grp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        any_ff, any_in;

   logic        accept;
   logic [7:0]  c;
   logic [7:0]  lc;
   logic [6:0]  sx;
   logic [23:0] full_grp;
   flush_type   fl;
   entry_type   ent;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign c              = req_chan.header_byte;

   // walk one byte through the parse phases
   always_comb begin
      phase_in = phase_ff;
      match_in = match_ff;
      grp_in   = grp_ff;
      cnt_in   = cnt_ff;
      any_in   = any_ff;
      ent      = '0;
      sx       = 7'd64;
      full_grp = '0;
      fl       = '0;
      lc       = (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;

      if (phase_in == PH_LEAD && c != CharSpace) begin
         phase_in = PH_MATCH;
      end

      if (phase_in == PH_MATCH) begin
         if (match_in < SchemeLen && lc == scheme_char(match_in)) begin
            match_in = match_in + 3'd1;
            if (match_in == SchemeLen) begin
               phase_in = PH_SKIP;
            end
         end else begin
            phase_in = PH_FAIL;
         end
      end else if (phase_in == PH_SKIP) begin
         if (c == CharNul) begin
            phase_in = PH_FAIL;
         end else if (c != CharSpace) begin
            any_in   = 1'b1;
            phase_in = PH_DECODE;
         end
      end

      // decode a sextet, or stop and flush the open group
      if (phase_in == PH_DECODE && any_in) begin
         sx = sextet_of(c);
         if (sx[6]) begin
            fl         = group_flush(grp_in, cnt_in);
            ent.bytes  = fl.bytes;
            ent.nbytes = fl.nbytes;
            grp_in     = '0;
            cnt_in     = 2'd0;
            phase_in   = PH_DONE;
         end else if (cnt_in == 2'd3) begin
            full_grp     = {grp_in, sx[5:0]};
            ent.bytes[0] = full_grp[23:16];
            ent.bytes[1] = full_grp[15:8];
            ent.bytes[2] = full_grp[7:0];
            ent.nbytes   = 2'd3;
            grp_in       = '0;
            cnt_in       = 2'd0;
         end else begin
            grp_in = {grp_in[11:0], sx[5:0]};
            cnt_in = cnt_in + 2'd1;
         end
      end

      // end of header: flush and report; keep the bytes of a group that just closed
      if (req_chan.is_last) begin
         if (phase_in == PH_DECODE) begin
            fl = group_flush(grp_in, cnt_in);
            if (cnt_in != 2'd0) begin
               ent.bytes  = fl.bytes;
               ent.nbytes = fl.nbytes;
            end
            phase_in = PH_DONE;
         end
         ent.has_status = 1'b1;
         ent.front_ok   = (phase_in == PH_DONE) && any_in;
         phase_in       = PH_LEAD;
         match_in       = 3'd0;
         grp_in         = '0;
         cnt_in         = 2'd0;
         any_in         = 1'b0;
      end
   end

   assign push       = accept && (ent.nbytes != 2'd0 || ent.has_status);
   assign push_entry = ent;

   // advance parse state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         match_ff <= 3'd0;
         grp_ff   <= '0;
         cnt_ff   <= 2'd0;
         any_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         match_ff <= match_in;
         grp_ff   <= grp_in;
         cnt_ff   <= cnt_in;
         any_ff   <= any_in;
      end
   end

endmodule

FILE: sv/bahd_queue.sv
// Short FIFO of decoded work between front and back.
module bahd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bahd_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output bahd_pkg::entry_type head_entry
);
   import bahd_pkg::*;

   entry_type              slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntW-1:0]   count_ff;
   logic                   do_push, do_pop;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // hold payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue push while full");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QueueCntW'(QueueDepth)) else $error("queue count overflow");

endmodule

FILE: sv/bahd_back.sv
// Back end: separates user and password, applies end of text, emits results.
module bahd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  bahd_pkg::entry_type head_entry,
   output logic                pop,
   bahd_rsp_if.source          rsp_chan
);
   import bahd_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       colon_ff, colon_in;
   logic       ended_ff, ended_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       pw_ff, stat_flag_ff, stat_ff;

   logic [7:0] cur_byte;
   logic [2:0] total;
   logic       status_step, last_step, emit, out_free, advance;

   assign total       = {1'b0, head_entry.nbytes} + {2'b00, head_entry.has_status};
   assign status_step = (idx_ff >= head_entry.nbytes);
   assign last_step   = ({1'b0, idx_ff} + 3'd1 == total);
   assign out_free    = !valid_ff || rsp_chan.ready;

   always_comb begin
      case (idx_ff)
         2'd0:    cur_byte = head_entry.bytes[0];
         2'd1:    cur_byte = head_entry.bytes[1];
         2'd2:    cur_byte = head_entry.bytes[2];
         default: cur_byte = 8'h00;
      endcase
   end

   // drop bytes after end of text, the zero byte and the first colon
   assign emit    = status_step ||
                    (!ended_ff && cur_byte != CharNul && !(cur_byte == CharColon && !colon_ff));
   assign advance = head_valid && (!emit || out_free);
   assign pop     = advance && last_step;

   always_comb begin
      idx_in   = idx_ff;
      colon_in = colon_ff;
      ended_in = ended_ff;
      if (advance) begin
         idx_in = last_step ? 2'd0 : idx_ff + 2'd1;
         if (status_step) begin
            colon_in = 1'b0;
            ended_in = 1'b0;
         end else if (!ended_ff) begin
            if (cur_byte == CharNul) begin
               ended_in = 1'b1;
            end else if (!colon_ff && cur_byte == CharColon) begin
               colon_in = 1'b1;
            end
         end
      end
   end

   assign valid_in = (advance && emit) ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);

   // step through the head entry
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         colon_ff <= 1'b0;
         ended_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         colon_ff <= colon_in;
         ended_ff <= ended_in;
         valid_ff <= valid_in;
      end
   end

   // load the output register
   always_ff @(posedge clock) begin
      if (advance && emit) begin
         data_ff      <= status_step ? 8'h00 : cur_byte;
         pw_ff        <= status_step ? 1'b0 : colon_ff;
         stat_flag_ff <= status_step;
         stat_ff      <= status_step && !(head_entry.front_ok && colon_ff);
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.data_byte   = data_ff;
   assign rsp_chan.is_password = pw_ff;
   assign rsp_chan.is_status   = stat_flag_ff;
   assign rsp_chan.status      = stat_ff;
   assign rsp_chan.last        = stat_flag_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ({1'b0, idx_ff} < total)) else $error("step index past entry");
   a_status_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && status_step) |=> (!colon_ff && !ended_ff && idx_ff == 2'd0))
      else $error("credential state not cleared after status");
   a_status_ends_entry: assert property (@(posedge clock) disable iff (reset)
      (advance && status_step) |-> pop) else $error("status step did not retire entry");
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |-> out_free) else $error("result overwritten");

endmodule
